// ----- rtl/freshness_score_fusion_assert.svh -----
// assertion macros for the freshness score fusion block
`ifndef FRESHNESS_SCORE_FUSION_ASSERT_SVH
`define FRESHNESS_SCORE_FUSION_ASSERT_SVH

// same-cycle implication
`define FSF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error("fsf assertion failed");

// next-cycle implication
`define FSF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error("fsf assertion failed");

`endif

// ----- rtl/fsf_pkg.sv -----
`timescale 1ns / 1ps
package fsf_pkg;

	typedef logic [1:0] mode_t;
	typedef logic [6:0] pct_t;

	typedef enum logic [1:0] {
		ST_FRESH   = 2'd0,
		ST_WARN    = 2'd1,
		ST_SPOILED = 2'd2
	} status_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
	} stage_en_t;

	localparam int SENSOR_A = 0;
	localparam int SENSOR_B = 1;

	localparam int PCT_MAX        = 100;
	localparam int FRESH_MIN      = 70;
	localparam int WARN_MIN       = 40;
	localparam int CLEAN_A_MAX    = 73;
	localparam int CLEAN_B_MAX    = 284;
	localparam int TEMP_SPAN      = 15;
	localparam int TEMP_MUL       = 27320;
	localparam int TEMP_SHIFT     = 12;
	localparam int RH_SHIFT       = 16;
	localparam int MEAN_SHIFT     = 20;
	localparam int NUM_LEVELS     = 100;

	localparam int A_FRESH  [4] = '{25, 50, 50, 30};
	localparam int A_BORDER [4] = '{100, 150, 150, 100};
	localparam int B_FRESH  [4] = '{10, 20, 30, 15};
	localparam int B_BORDER [4] = '{50, 100, 150, 80};
	localparam int TEMP_MAX [4] = '{4, 25, 20, 7};
	localparam int RH_SAFE  [4] = '{85, 75, 95, 90};
	localparam int RH_DANGER[4] = '{95, 85, 100, 97};
	localparam int RH_MUL   [4] = '{655400, 655400, 1310800, 936300};
	localparam int W_A      [4] = '{56, 25, 22, 32};
	localparam int W_B      [4] = '{17, 42, 50, 37};
	localparam int W_T      [4] = '{27, 33, 28, 31};
	localparam int W_H      [4] = '{10, 40, 10, 5};
	localparam int W_SUM    [4] = '{110, 140, 110, 105};
	localparam int W_RECIP  [4] = '{9532, 7489, 9532, 9986};

	localparam longint GAIN[50] = '{
		0,     891,   1782,  2675,  3569,  4467,  5368,  6274,  7185,  8102,
		9026,  9958,  10898, 11848, 12808, 13780, 14766, 15765, 16780, 17811,
		18862, 19932, 21025, 22141, 23284, 24456, 25660, 26898, 28175, 29494,
		30860, 32278, 33755, 35297, 36914, 38614, 40410, 42317, 44353, 46542,
		48912, 51504, 54369, 57582, 61252, 65546, 70746, 77381, 86635, 102291
	};
	localparam longint GAIN_TOP = 117834;

	// adc level of a profile's fresh or borderline point
	function automatic longint gas_level(int sensor, int mode, bit border, int adc_bits);
		longint fs;
		longint ppm;
		fs = (longint'(1) <<< adc_bits) - 1;
		if (sensor == SENSOR_A) begin
			ppm = border ? A_BORDER[mode] : A_FRESH[mode];
			return 57 + 343 * ppm / 200;
		end
		ppm = border ? B_BORDER[mode] : B_FRESH[mode];
		return 247 + (fs - 247) * ppm / 400;
	endfunction

	// threshold on 2*raw for level lvl (1..99, 100 is the top step), clamped
	function automatic longint gas_cmp(int sensor, int mode, int lvl, int adc_bits);
		longint f;
		longint b;
		longint s;
		longint d;
		longint n;
		longint t;
		longint c;
		longint cmax;
		f = gas_level(sensor, mode, 1'b0, adc_bits);
		b = gas_level(sensor, mode, 1'b1, adc_bits);
		s = f + b;
		d = b - f;
		if (d < 2) d = 2;
		if (lvl == NUM_LEVELS) begin
			t = ((d * GAIN_TOP) >>> 16) + 1;
		end else begin
			n = (lvl >= 50) ? d * GAIN[lvl - 50] : -(d * GAIN[50 - lvl]);
			t = -((-n) >>> 16);
		end
		c = s + t;
		cmax = longint'(1) <<< (adc_bits + 1);
		if (c < 0) c = 0;
		if (c > cmax) c = cmax;
		return c;
	endfunction

endpackage

// ----- rtl/fsf_if.sv -----
`timescale 1ns / 1ps
interface fsf_sample_if #(parameter int ADC_BITS = 12);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] gas_a_raw;
	logic [ADC_BITS-1:0] gas_b_raw;
	logic signed [7:0]   temp_celsius;
	logic [6:0]          rel_humidity;
	modport source(output valid, gas_a_raw, gas_b_raw, temp_celsius, rel_humidity,
		input ready);
	modport sink(input valid, gas_a_raw, gas_b_raw, temp_celsius, rel_humidity,
		output ready);
endinterface

interface fsf_result_if;
	logic       valid;
	logic       ready;
	logic [6:0] fresh_score;
	logic [1:0] fresh_status;
	logic [6:0] gas_a_pct;
	logic [6:0] gas_b_pct;
	modport source(output valid, fresh_score, fresh_status, gas_a_pct, gas_b_pct,
		input ready);
	modport sink(input valid, fresh_score, fresh_status, gas_a_pct, gas_b_pct,
		output ready);
endinterface

interface fsf_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] food_mode;
	modport source(output valid, food_mode, input ready);
	modport sink(input valid, food_mode, output ready);
endinterface

// ----- rtl/freshness_score_fusion.sv -----
`timescale 1ns / 1ps
// an accepted sample word reaches its result word through register stages s1 to s5
// throughput: one sample word per cycle while the result port does not stall, the five register stages move together
// a stall at the result port holds every stage; sample ready follows the last stage
// reset: arst_n clears all stage valid bits and sets food_mode to meat (0)
// no memories and no clearing pass after reset
module freshness_score_fusion #(
	parameter int ADC_BITS = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	fsf_sample_if.sink     sample,
	fsf_result_if.source   result,
	fsf_cfg_if.sink        cfg
);

	fsf_pkg::mode_t     mode_q;
	logic               advance;
	fsf_pkg::stage_en_t en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [8:0] tdiff;
	logic [18:0]       tprod;
	fsf_pkg::pct_t     pt;
	logic [3:0]        rh_n;
	logic [24:0]       rh_prod;
	fsf_pkg::pct_t     ph;
	logic              clean;

	fsf_pkg::pct_t  pt_s1, ph_s1, pt_s2, ph_s2;
	logic           clean_s1, clean_s2, clean_s3, clean_s4;
	fsf_pkg::mode_t mode_s1, mode_s2, mode_s3, mode_s4;

	fsf_pkg::pct_t pa_s2, pb_s2, pa_s3, pb_s3, pa_s4, pb_s4, pa_s5, pb_s5;
	logic [13:0]   wsum;
	logic [13:0]   wsum_s3, wsum_s4;
	logic [27:0]   qprod;
	fsf_pkg::pct_t q_s4;
	logic [13:0]   qw;
	logic [13:0]   rem;
	fsf_pkg::pct_t mean;
	fsf_pkg::pct_t score;
	fsf_pkg::status_t status;
	fsf_pkg::pct_t score_s5;
	fsf_pkg::status_t status_s5;

	assign advance    = !v_s5 || result.ready;
	assign en.load_s1 = advance;
	assign en.load_s2 = advance;
	assign sample.ready = advance;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (cfg.valid) begin
			mode_q <= cfg.food_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: ramps, clean-air check, gas thermometers
	always_comb begin
		tdiff = $signed({sample.temp_celsius[7], sample.temp_celsius})
			- 9'(fsf_pkg::TEMP_MAX[mode_q]);
		tprod = 19'(tdiff[3:0]) * 19'(fsf_pkg::TEMP_MUL);
		if (tdiff <= 9'sd0) begin
			pt = '0;
		end else if (tdiff >= 9'(fsf_pkg::TEMP_SPAN)) begin
			pt = 7'(fsf_pkg::PCT_MAX);
		end else begin
			pt = 7'(tprod >> fsf_pkg::TEMP_SHIFT);
		end

		rh_n    = 4'(sample.rel_humidity - 7'(fsf_pkg::RH_SAFE[mode_q]));
		rh_prod = 25'(rh_n) * 25'(fsf_pkg::RH_MUL[mode_q]);
		if (sample.rel_humidity <= 7'(fsf_pkg::RH_SAFE[mode_q])) begin
			ph = '0;
		end else if (sample.rel_humidity >= 7'(fsf_pkg::RH_DANGER[mode_q])) begin
			ph = 7'(fsf_pkg::PCT_MAX);
		end else begin
			ph = 7'(rh_prod >> fsf_pkg::RH_SHIFT);
		end

		clean = (sample.gas_a_raw <= ADC_BITS'(fsf_pkg::CLEAN_A_MAX))
			&& (sample.gas_b_raw <= ADC_BITS'(fsf_pkg::CLEAN_B_MAX));
	end

	fsf_gas_pct #(.ADC_BITS(ADC_BITS), .SENSOR(fsf_pkg::SENSOR_A)) u_gas_a (
		.clk    (clk),
		.en     (en),
		.raw    (sample.gas_a_raw),
		.mode   (mode_q),
		.pct_s2 (pa_s2)
	);

	fsf_gas_pct #(.ADC_BITS(ADC_BITS), .SENSOR(fsf_pkg::SENSOR_B)) u_gas_b (
		.clk    (clk),
		.en     (en),
		.raw    (sample.gas_b_raw),
		.mode   (mode_q),
		.pct_s2 (pb_s2)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			pt_s1    <= pt;
			ph_s1    <= ph;
			clean_s1 <= clean;
			mode_s1  <= mode_q;
			pt_s2    <= pt_s1;
			ph_s2    <= ph_s1;
			clean_s2 <= clean_s1;
			mode_s2  <= mode_s1;
		end
	end

	// stage 3: weighted sum
	assign wsum = 14'(pa_s2) * 14'(fsf_pkg::W_A[mode_s2])
		+ 14'(pb_s2) * 14'(fsf_pkg::W_B[mode_s2])
		+ 14'(pt_s2) * 14'(fsf_pkg::W_T[mode_s2])
		+ 14'(ph_s2) * 14'(fsf_pkg::W_H[mode_s2]);

	always_ff @(posedge clk) begin
		if (advance) begin
			wsum_s3  <= wsum;
			pa_s3    <= pa_s2;
			pb_s3    <= pb_s2;
			clean_s3 <= clean_s2;
			mode_s3  <= mode_s2;
		end
	end

	// stage 4: quotient estimate by reciprocal, low by at most one
	assign qprod = 28'(wsum_s3) * 28'(fsf_pkg::W_RECIP[mode_s3]);

	always_ff @(posedge clk) begin
		if (advance) begin
			q_s4     <= 7'(qprod >> fsf_pkg::MEAN_SHIFT);
			wsum_s4  <= wsum_s3;
			pa_s4    <= pa_s3;
			pb_s4    <= pb_s3;
			clean_s4 <= clean_s3;
			mode_s4  <= mode_s3;
		end
	end

	// stage 5: quotient correction, score and status
	always_comb begin
		qw  = 14'(q_s4) * 14'(fsf_pkg::W_SUM[mode_s4]);
		rem = wsum_s4 - qw;
		if (rem >= 14'(fsf_pkg::W_SUM[mode_s4])) begin
			mean = q_s4 + 7'd1;
		end else begin
			mean = q_s4;
		end
		if (clean_s4) begin
			score = 7'(fsf_pkg::PCT_MAX);
		end else begin
			score = 7'(fsf_pkg::PCT_MAX) - mean;
		end
		priority if (score >= 7'(fsf_pkg::FRESH_MIN)) begin
			status = fsf_pkg::ST_FRESH;
		end else if (score >= 7'(fsf_pkg::WARN_MIN)) begin
			status = fsf_pkg::ST_WARN;
		end else begin
			status = fsf_pkg::ST_SPOILED;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			score_s5  <= score;
			status_s5 <= status;
			pa_s5     <= clean_s4 ? '0 : pa_s4;
			pb_s5     <= clean_s4 ? '0 : pb_s4;
		end
	end

	assign result.valid        = v_s5;
	assign result.fresh_score  = score_s5;
	assign result.fresh_status = status_s5;
	assign result.gas_a_pct    = pa_s5;
	assign result.gas_b_pct    = pb_s5;

endmodule

// ----- rtl/fsf_gas_pct.sv -----
`timescale 1ns / 1ps
module fsf_gas_pct #(
	parameter int ADC_BITS = 12,
	parameter int SENSOR   = 0
) (
	input  logic                clk,
	input  fsf_pkg::stage_en_t  en,
	input  logic [ADC_BITS-1:0] raw,
	input  fsf_pkg::mode_t      mode,
	output fsf_pkg::pct_t       pct_s2
);

	localparam int CW = ADC_BITS + 2;
	localparam int NL = fsf_pkg::NUM_LEVELS;

	logic [CW-1:0] thr [4][NL];
	logic [CW-1:0] dbl;
	logic [NL-1:0] therm;
	logic [NL-1:0] therm_s1;
	logic [NL:0]   therm_x;
	fsf_pkg::pct_t cnt;

	for (genvar m = 0; m < 4; m++) begin : g_mode
		for (genvar p = 0; p < NL; p++) begin : g_lvl
			localparam longint C = fsf_pkg::gas_cmp(SENSOR, m, p + 1, ADC_BITS);
			assign thr[m][p] = CW'(C);
		end
	end

	assign dbl = {1'b0, raw, 1'b0};

	always_comb begin
		for (int p = 0; p < NL; p++) begin
			therm[p] = (dbl >= thr[mode][p]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.load_s1) begin
			therm_s1 <= therm;
		end
	end

	// thresholds rise with the level, so the word is a thermometer code
	assign therm_x = {1'b0, therm_s1};

	always_comb begin
		cnt = '0;
		for (int p = 0; p < NL; p++) begin
			if (therm_x[p] && !therm_x[p + 1]) begin
				cnt = cnt | 7'(p + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.load_s2) begin
			pct_s2 <= cnt;
		end
	end

endmodule

// ----- rtl/fsf_checker.sv -----
`timescale 1ns / 1ps
`include "freshness_score_fusion_assert.svh"
module fsf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] score,
	input logic [1:0] status,
	input logic [6:0] pa,
	input logic [6:0] pb
);

	`FSF_ASSERT_IMP(a_full_is_fresh, clk, arst_n, out_valid && score == 7'd100, status == fsf_pkg::ST_FRESH)
	`FSF_ASSERT_IMP(a_low_is_spoiled, clk, arst_n, out_valid && score < 7'd40, status == fsf_pkg::ST_SPOILED)
	`FSF_ASSERT_IMP(a_in_range, clk, arst_n, out_valid, score <= 7'd100 && pa <= 7'd100 && pb <= 7'd100)
	`FSF_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(score) && $stable(status))

endmodule

bind freshness_score_fusion fsf_checker u_fsf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.score     (result.fresh_score),
	.status    (result.fresh_status),
	.pa        (result.gas_a_pct),
	.pb        (result.gas_b_pct)
);
